FILE: rtl/hgba_pkg.sv
package hgba_pkg;

   // Aggregate function codes held in the agg_function register.
   localparam logic [2:0] AGG_MIN       = 3'd0;
   localparam logic [2:0] AGG_MAX       = 3'd1;
   localparam logic [2:0] AGG_SUM       = 3'd2;
   localparam logic [2:0] AGG_AVG       = 3'd3;
   localparam logic [2:0] AGG_COUNT     = 3'd4;
   localparam logic [2:0] AGG_COUNT_ALL = 3'd5;

   // Configuration register indexes.
   localparam logic CSR_AGG_FUNCTION = 1'b0;
   localparam logic CSR_GROUP_BY     = 1'b1;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_CHECK,
      ST_INSERT,
      ST_FLUSH_READ,
      ST_FLUSH_USE,
      ST_FLUSH_DIV,
      ST_FLUSH_EMIT
   } state_type;

endpackage

FILE: rtl/hash_group_by_aggregator_core.sv
// Group-by aggregation engine. A row beat (req_op low) is accepted when start is high and busy
// is low; its group is looked up by walking the group table, which sits in one synchronous
// memory, one entry at a time through a read state and a compare state. Busy stays high until
// the row has been applied to its group. A new key first walks all n groups in use and
// then inserts its group (it goes straight to the insert when the table is empty);
// a new key that meets a full table is dropped once the walk is over.
// A flush beat (req_op high) returns one result beat per group in
// first-seen order. In avg mode, the average of a group with values comes from a restoring
// divider that produces one quotient bit per cycle. Result beats are marked by rsp_valid for one
// cycle each and cannot be stalled; rsp_last flags the final beat of a flush, and the table is
// empty once it has gone out. Configuration writes are taken at any time but must only be made
// while busy is low.
module hash_group_by_aggregator_core #(
   parameter int MAX_GROUPS = 64,
   parameter int KEY_WIDTH  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [63:0] req_group_key,
   input  logic        req_key_is_null,
   input  logic signed [31:0] req_row_value,
   input  logic        req_value_is_null,
   output logic        rsp_valid,
   output logic [63:0] rsp_out_key,
   output logic        rsp_out_key_null,
   output logic signed [63:0] rsp_agg_value,
   output logic        rsp_agg_is_null,
   output logic        rsp_overflow,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [2:0]  csr_wdata
);

   localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int CW = $clog2(MAX_GROUPS + 1);

   typedef struct packed {
      logic [KEY_WIDTH-1:0] key;
      logic                 knull;
      logic [63:0]          agg;
      logic                 has;
      logic [31:0]          cnt;
   } entry_type;

   hgba_pkg::state_type state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] used_ff, used_in;
   logic          ovf_ff, ovf_in;
   logic [2:0]    agg_fn_ff;
   logic          group_by_ff;

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic          knull_ff, knull_in;
   logic [63:0]   val_ff, val_in;
   logic          vnull_ff, vnull_in;

   logic [63:0]   quo_ff, quo_in;
   logic [31:0]   rem_ff, rem_in;
   logic [5:0]    dcnt_ff, dcnt_in;
   logic          neg_ff, neg_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_key_ff, rsp_key_in;
   logic          rsp_knull_ff, rsp_knull_in;
   logic [63:0]   rsp_val_ff, rsp_val_in;
   logic          rsp_vnull_ff, rsp_vnull_in;
   logic          rsp_last_ff, rsp_last_in;

   entry_type     mem [MAX_GROUPS];
   entry_type     rd_q_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;

   entry_type     fresh, base, updated;
   logic          hit, at_end, div_ge;
   logic [32:0]   rem_sh;
   logic [63:0]   mag;

   assign busy             = (state_ff != hgba_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_key      = rsp_key_ff;
   assign rsp_out_key_null = rsp_knull_ff;
   assign rsp_agg_value    = rsp_val_ff;
   assign rsp_agg_is_null  = rsp_vnull_ff;
   assign rsp_overflow     = ovf_ff;
   assign rsp_last         = rsp_last_ff;

   // The group table: written at one address, read at the scan index with registered data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         agg_fn_ff   <= hgba_pkg::AGG_COUNT;
         group_by_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            hgba_pkg::CSR_AGG_FUNCTION: agg_fn_ff   <= csr_wdata;
            hgba_pkg::CSR_GROUP_BY:     group_by_ff <= csr_wdata[0];
            default:                    agg_fn_ff   <= agg_fn_ff;
         endcase
      end
   end

   // Row update, applied either to the matching entry or to a freshly opened one.
   always_comb begin
      fresh       = '0;
      fresh.key   = key_ff;
      fresh.knull = knull_ff;
      base        = (state_ff == hgba_pkg::ST_CHECK) ? rd_q_ff : fresh;
      updated     = base;
      if (agg_fn_ff == hgba_pkg::AGG_COUNT_ALL) begin
         if (base.cnt != hgba_pkg::COUNT_MAX) begin
            updated.cnt = base.cnt + 32'd1;
         end
      end else if (agg_fn_ff <= hgba_pkg::AGG_COUNT && !vnull_ff) begin
         priority if (agg_fn_ff == hgba_pkg::AGG_MIN) begin
            if (!base.has || ($signed(val_ff) < $signed(base.agg))) updated.agg = val_ff;
         end else if (agg_fn_ff == hgba_pkg::AGG_MAX) begin
            if (!base.has || ($signed(base.agg) < $signed(val_ff))) updated.agg = val_ff;
         end else if (agg_fn_ff == hgba_pkg::AGG_SUM || agg_fn_ff == hgba_pkg::AGG_AVG) begin
            updated.agg = base.has ? base.agg + val_ff : val_ff;
         end else begin
            updated.agg = base.agg;
         end
         updated.has = 1'b1;
         if (base.cnt != hgba_pkg::COUNT_MAX) begin
            updated.cnt = base.cnt + 32'd1;
         end
      end
   end

   assign hit    = (rd_q_ff.knull == knull_ff) && (rd_q_ff.key == key_ff);
   assign at_end = ((CW'(idx_ff) + CW'(1)) == used_ff);
   assign rem_sh = {rem_ff, quo_ff[63]};
   assign div_ge = (rem_sh >= {1'b0, rd_q_ff.cnt});
   assign mag    = rd_q_ff.agg[63] ? (64'd0 - rd_q_ff.agg) : rd_q_ff.agg;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      used_in      = used_ff;
      ovf_in       = ovf_ff;
      key_in       = key_ff;
      knull_in     = knull_ff;
      val_in       = val_ff;
      vnull_in     = vnull_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = 1'b0;
      rsp_key_in   = rsp_key_ff;
      rsp_knull_in = rsp_knull_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_vnull_in = rsp_vnull_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = AW'(used_ff);
      mem_wdata    = updated;

      unique case (state_ff)
         hgba_pkg::ST_IDLE: begin
            if (start) begin
               idx_in = '0;
               if (req_op) begin
                  if (used_ff == '0) begin
                     // An empty flush without grouping still reports the global group.
                     if (!group_by_ff && agg_fn_ff <= hgba_pkg::AGG_COUNT_ALL) begin
                        rsp_valid_in = 1'b1;
                        rsp_key_in   = '0;
                        rsp_knull_in = 1'b0;
                        rsp_val_in   = '0;
                        rsp_vnull_in = (agg_fn_ff <= hgba_pkg::AGG_AVG);
                        rsp_last_in  = 1'b1;
                     end
                  end else begin
                     state_in = hgba_pkg::ST_FLUSH_READ;
                  end
               end else begin
                  knull_in = group_by_ff & req_key_is_null;
                  key_in   = (group_by_ff && !req_key_is_null) ?
                             req_group_key[KEY_WIDTH-1:0] : '0;
                  val_in   = {{32{req_row_value[31]}}, req_row_value};
                  vnull_in = req_value_is_null;
                  state_in = (used_ff == '0) ? hgba_pkg::ST_INSERT : hgba_pkg::ST_LOOK;
               end
            end
         end
         hgba_pkg::ST_LOOK: begin
            state_in = hgba_pkg::ST_CHECK;
         end
         hgba_pkg::ST_CHECK: begin
            if (hit) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               state_in  = hgba_pkg::ST_IDLE;
            end else if (!at_end) begin
               idx_in   = idx_ff + AW'(1);
               state_in = hgba_pkg::ST_LOOK;
            end else if (used_ff >= CW'(MAX_GROUPS)) begin
               ovf_in   = 1'b1;
               state_in = hgba_pkg::ST_IDLE;
            end else begin
               state_in = hgba_pkg::ST_INSERT;
            end
         end
         hgba_pkg::ST_INSERT: begin
            mem_we   = 1'b1;
            used_in  = used_ff + CW'(1);
            state_in = hgba_pkg::ST_IDLE;
         end
         hgba_pkg::ST_FLUSH_READ: begin
            state_in = hgba_pkg::ST_FLUSH_USE;
         end
         hgba_pkg::ST_FLUSH_USE: begin
            rsp_key_in   = 64'(rd_q_ff.key);
            rsp_knull_in = rd_q_ff.knull;
            rsp_last_in  = at_end;
            rsp_vnull_in = 1'b0;
            rsp_val_in   = '0;
            if (agg_fn_ff == hgba_pkg::AGG_AVG && rd_q_ff.has) begin
               quo_in   = mag;
               rem_in   = '0;
               dcnt_in  = 6'd63;
               neg_in   = rd_q_ff.agg[63];
               state_in = hgba_pkg::ST_FLUSH_DIV;
            end else begin
               if (agg_fn_ff <= hgba_pkg::AGG_AVG) begin
                  rsp_vnull_in = !rd_q_ff.has;
                  rsp_val_in   = rd_q_ff.has ? rd_q_ff.agg : '0;
               end else if (agg_fn_ff <= hgba_pkg::AGG_COUNT_ALL) begin
                  rsp_val_in = 64'(rd_q_ff.cnt);
               end
               rsp_valid_in = 1'b1;
               if (at_end) begin
                  used_in  = '0;
                  state_in = hgba_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = hgba_pkg::ST_FLUSH_READ;
               end
            end
         end
         hgba_pkg::ST_FLUSH_DIV: begin
            // Restoring division, one quotient bit per cycle; the remainder stays below cnt.
            rem_in = div_ge ? 32'(rem_sh - {1'b0, rd_q_ff.cnt}) : rem_sh[31:0];
            quo_in = {quo_ff[62:0], div_ge};
            if (dcnt_ff == '0) begin
               state_in = hgba_pkg::ST_FLUSH_EMIT;
            end else begin
               dcnt_in = dcnt_ff - 6'd1;
            end
         end
         hgba_pkg::ST_FLUSH_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_val_in   = neg_ff ? (64'd0 - quo_ff) : quo_ff;
            if (at_end) begin
               used_in  = '0;
               state_in = hgba_pkg::ST_IDLE;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = hgba_pkg::ST_FLUSH_READ;
            end
         end
         default: begin
            state_in = hgba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hgba_pkg::ST_IDLE;
         used_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      knull_ff     <= knull_in;
      val_ff       <= val_in;
      vnull_ff     <= vnull_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      dcnt_ff      <= dcnt_in;
      neg_ff       <= neg_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_knull_ff <= rsp_knull_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_vnull_ff <= rsp_vnull_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // The table never holds more groups than it has slots.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(MAX_GROUPS))
      else $error("group count exceeds table size");

   // Once the final beat of a flush is out, the table is empty.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (used_ff == '0))
      else $error("table not cleared after last beat");

   // Overflow is sticky until reset.
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag dropped");

endmodule
